### design/fdrt_pkg.sv
package fdrt_pkg;

  localparam int STORE_DEPTH = 65536;
  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = 8;

  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int DELAY_W     = 24;
  localparam int FB_W        = 15;
  localparam int MIX_GAIN_W  = 16;
  localparam int GAIN_SHIFT  = 15;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 24;

  localparam int FB_PROD_W   = SAMPLE_BITS + FB_W + 1;
  localparam int MIX_PROD_W  = SAMPLE_BITS + MIX_GAIN_W + 1;
  localparam int MIX_SUM_W   = MIX_PROD_W + 1;

  localparam logic [FB_W-1:0]       FB_CAP         = FB_W'(32440);
  localparam logic [MIX_GAIN_W-1:0] UNITY_GAIN     = MIX_GAIN_W'(32768);
  localparam logic [MIX_GAIN_W-1:0] WET_GAIN_RST   = MIX_GAIN_W'(16384);
  localparam logic [DELAY_W-1:0]    ONE_SAMPLE     = DELAY_W'(2 ** FRAC_BITS);
  localparam logic [DELAY_W-1:0]    TARGET_RST     = DELAY_W'(256);
  localparam logic [DELAY_W-1:0]    RAMP_STEP_RST  = DELAY_W'(256);

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [ADDR_W-1:0] addr_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET_DELAY  = 3'd0,
    REG_RAMP_STEP     = 3'd1,
    REG_FEEDBACK_GAIN = 3'd2,
    REG_WET_GAIN      = 3'd3,
    REG_DRY_GAIN      = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

endpackage

### design/fdrt_store.sv
module fdrt_store import fdrt_pkg::*; (
  input  logic    clk,
  input  logic    we,
  input  addr_t   waddr,
  input  sample_t wdata,
  input  logic    re,
  input  addr_t   raddr,
  output sample_t rdata
);

  logic [SAMPLE_BITS-1:0] mem [STORE_DEPTH];
  logic [SAMPLE_BITS-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = sample_t'(rdata_r);

endmodule

### design/fdrt_ramp.sv
module fdrt_ramp import fdrt_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  cfg_wr_t cfg_wr,
  input  logic    advance,
  output addr_t   delay_int
);

  logic [DELAY_W-1:0] tgt_r, step_r, cur_r;
  logic               active_r;

  logic [DELAY_W:0]   diff, diff_neg;
  logic               below;
  logic [DELAY_W-1:0] mag, moved, tgt_wr;
  logic               snap;
  logic [31:0]        d_ext, d_clamp;

  // distance and step toward the target
  always_comb begin
    diff     = {1'b0, tgt_r} - {1'b0, cur_r};
    diff_neg = -diff;
    below    = diff[DELAY_W];
    mag      = below ? diff_neg[DELAY_W-1:0] : diff[DELAY_W-1:0];
    snap     = ({1'b0, mag} < {step_r, 1'b0});
    moved    = below ? (cur_r - step_r) : (cur_r + step_r);
  end

  always_comb begin
    tgt_wr = cfg_wr.data[DELAY_W-1:0];
    if (tgt_wr < ONE_SAMPLE) begin
      tgt_wr = ONE_SAMPLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_r    <= TARGET_RST;
      step_r   <= RAMP_STEP_RST;
      cur_r    <= ONE_SAMPLE;
      active_r <= 1'b1;
    end else if (cfg_wr.we) begin
      unique case (cfg_reg_t'(cfg_wr.idx))
        REG_TARGET_DELAY: begin
          tgt_r    <= tgt_wr;
          active_r <= 1'b1;
        end
        REG_RAMP_STEP: begin
          step_r <= cfg_wr.data[DELAY_W-1:0];
        end
        default: ;
      endcase
    end else if (advance && active_r) begin
      cur_r    <= snap ? tgt_r : moved;
      active_r <= !snap;
    end
  end

  // integer delay held between one sample and one less than the store depth
  always_comb begin
    d_ext = 32'(cur_r[DELAY_W-1:FRAC_BITS]);
    priority if (d_ext == 32'd0) begin
      d_clamp = 32'd1;
    end else if (d_ext > 32'(STORE_DEPTH - 1)) begin
      d_clamp = 32'(STORE_DEPTH - 1);
    end else begin
      d_clamp = d_ext;
    end
  end

  assign delay_int = d_clamp[ADDR_W-1:0];

endmodule

### design/feedback_delay_with_ramped_time.sv
// channel | direction | handshake             | payload
// in      | input     | in_valid / in_ready   | sample_in  (16 bit signed)
// out     | output    | out_valid / out_ready | sample_out (16 bit signed)
// cfg     | input     | cfg_valid / cfg_ready | cfg_index (3 bit), cfg_data (24 bit)
//
// a request is not taken while the last one is in stage 1: the delayed sample read
// from the echo store feeds the next sample's write, through the registered store read
// a result moves through s1_v_r, s2_v_r and s3_v_r to out_valid; s3 holds while stalled
// synchronous reset, no clearing pass: entries not yet written since reset read as zero
// up to two requests in flight; a stalled output holds the input off
module feedback_delay_with_ramped_time import fdrt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  sample_t               sample_in,
  output logic                  out_valid,
  input  logic                  out_ready,
  output sample_t               sample_out,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [1:0] MAX_INFLIGHT = 2'd2;
  localparam logic signed [MIX_SUM_W-1:0] ROUND_HALF = MIX_SUM_W'(2 ** (GAIN_SHIFT - 1));

  function automatic sample_t sat_sample(input logic signed [MIX_SUM_W-1:0] v);
    logic signed [MIX_SUM_W-1:0] hi, lo;
    hi = {{(MIX_SUM_W-SAMPLE_BITS){1'b0}}, SAMPLE_MAX};
    lo = {{(MIX_SUM_W-SAMPLE_BITS){1'b1}}, SAMPLE_MIN};
    if (v > hi) begin
      return SAMPLE_MAX;
    end else if (v < lo) begin
      return SAMPLE_MIN;
    end
    return sample_t'(v[SAMPLE_BITS-1:0]);
  endfunction

  cfg_wr_t cfg_wr;
  logic    in_fire, out_fire, cfg_fire;

  logic [FB_W-1:0]       fb_gain_r;
  logic [MIX_GAIN_W-1:0] wet_gain_r, dry_gain_r;
  logic [FB_W-1:0]       fb_wr;
  logic [MIX_GAIN_W-1:0] wet_wr, dry_wr;
  logic                  fb_refresh_r;

  logic       s1_v_r, s2_v_r, s3_v_r, out_valid_r;
  logic [1:0] cnt_r;
  logic       s3_move;

  sample_t x_r, last_r, out_data_r;
  logic signed [MIX_PROD_W-1:0] dry1_r, dry2_r, dry3_r, wet_prod_r;
  logic signed [FB_PROD_W-1:0]  fb_prod_r;

  addr_t wp_r;
  logic  wrap_r, rd_ok_r;
  addr_t delay_int, rd_addr;
  logic [ADDR_W:0] rd_diff, rd_wrapped;
  logic  borrow;

  logic signed [MIX_SUM_W-1:0] fb_sum, fb_rnd, fed_sum;
  logic signed [MIX_SUM_W-1:0] mix_sum, mix_rnd;
  sample_t fed, rdata, delayed, fb_opnd;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid_r && out_ready;
  assign cfg_fire = cfg_valid && cfg_ready;
  assign cfg_ready = 1'b1;

  assign cfg_wr = '{we: cfg_fire, idx: cfg_index, data: cfg_data};

  assign in_ready = !s1_v_r && !fb_refresh_r &&
                    ((cnt_r < MAX_INFLIGHT) || ((cnt_r == MAX_INFLIGHT) && out_fire));

  // gain registers
  always_comb begin
    fb_wr  = cfg_data[FB_W-1:0];
    wet_wr = cfg_data[MIX_GAIN_W-1:0];
    dry_wr = cfg_data[MIX_GAIN_W-1:0];
    if (fb_wr > FB_CAP) begin
      fb_wr = FB_CAP;
    end
    if (wet_wr > UNITY_GAIN) begin
      wet_wr = UNITY_GAIN;
    end
    if (dry_wr > UNITY_GAIN) begin
      dry_wr = UNITY_GAIN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fb_gain_r    <= '0;
      wet_gain_r   <= WET_GAIN_RST;
      dry_gain_r   <= UNITY_GAIN;
      fb_refresh_r <= 1'b0;
    end else begin
      fb_refresh_r <= 1'b0;
      if (cfg_fire) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_FEEDBACK_GAIN: begin
            fb_gain_r    <= fb_wr;
            fb_refresh_r <= 1'b1;
          end
          REG_WET_GAIN: wet_gain_r <= wet_wr;
          REG_DRY_GAIN: dry_gain_r <= dry_wr;
          default: ;
        endcase
      end
    end
  end

  fdrt_ramp u_ramp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr    (cfg_wr),
    .advance   (in_fire),
    .delay_int (delay_int)
  );

  // stage 1: feedback sum, store write and delayed read
  always_comb begin
    fb_sum  = {{(MIX_SUM_W-FB_PROD_W){fb_prod_r[FB_PROD_W-1]}}, fb_prod_r} + ROUND_HALF;
    fb_rnd  = fb_sum >>> GAIN_SHIFT;
    fed_sum = {{(MIX_SUM_W-SAMPLE_BITS){x_r[SAMPLE_BITS-1]}}, x_r} + fb_rnd;
    fed     = sat_sample(fed_sum);
  end

  always_comb begin
    rd_diff    = {1'b0, wp_r} - {1'b0, delay_int};
    rd_wrapped = rd_diff + (ADDR_W+1)'(STORE_DEPTH);
    borrow     = rd_diff[ADDR_W];
    rd_addr    = borrow ? rd_wrapped[ADDR_W-1:0] : rd_diff[ADDR_W-1:0];
  end

  fdrt_store u_store (
    .clk   (clk),
    .we    (s1_v_r),
    .waddr (wp_r),
    .wdata (fed),
    .re    (s1_v_r),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  // stage 2: delayed sample, products for the mix and the next feedback
  assign delayed = rd_ok_r ? rdata : '0;
  assign fb_opnd = s2_v_r ? delayed : last_r;

  // stage 3: output mix
  always_comb begin
    mix_sum = {{(MIX_SUM_W-MIX_PROD_W){wet_prod_r[MIX_PROD_W-1]}}, wet_prod_r} +
              {{(MIX_SUM_W-MIX_PROD_W){dry3_r[MIX_PROD_W-1]}}, dry3_r} + ROUND_HALF;
    mix_rnd = mix_sum >>> GAIN_SHIFT;
  end

  assign s3_move = s3_v_r && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      wp_r        <= '0;
      wrap_r      <= 1'b0;
      last_r      <= '0;
      fb_prod_r   <= '0;
    end else begin
      cnt_r  <= cnt_r + 2'(in_fire) - 2'(out_fire);
      s1_v_r <= in_fire;
      s2_v_r <= s1_v_r;
      if (s1_v_r) begin
        if (wp_r == ADDR_W'(STORE_DEPTH - 1)) begin
          wp_r   <= '0;
          wrap_r <= 1'b1;
        end else begin
          wp_r <= wp_r + 1'b1;
        end
      end
      if (s2_v_r) begin
        last_r <= delayed;
      end
      if (s2_v_r || fb_refresh_r) begin
        fb_prod_r <= fb_opnd * $signed({1'b0, fb_gain_r});
      end
      if (s2_v_r) begin
        s3_v_r <= 1'b1;
      end else if (s3_move) begin
        s3_v_r <= 1'b0;
      end
      if (s3_move) begin
        out_valid_r <= 1'b1;
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      x_r    <= sample_in;
      dry1_r <= sample_in * $signed({1'b0, dry_gain_r});
    end
    if (s1_v_r) begin
      dry2_r  <= dry1_r;
      rd_ok_r <= wrap_r || !borrow;
    end
    if (s2_v_r) begin
      dry3_r     <= dry2_r;
      wet_prod_r <= delayed * $signed({1'b0, wet_gain_r});
    end
    if (s3_move) begin
      out_data_r <= sat_sample(mix_rnd);
    end
  end

  assign out_valid  = out_valid_r;
  assign sample_out = out_data_r;

endmodule
